// File: hdl/ray_triangle_nearest_hit_macros.svh
// Assertion macros for the ray/triangle nearest-hit block.
// Included by the top level; no other dependencies.
`ifndef RAY_TRIANGLE_NEAREST_HIT_MACROS_SVH
`define RAY_TRIANGLE_NEAREST_HIT_MACROS_SVH
`ifndef SYNTH
`define RTNH_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define RTNH_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RTNH_ASSERT_IMPL(label, clk, rstn, prop)
`define RTNH_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hdl/rtnh_pkg.sv
// Shared types and constants for the ray/triangle nearest-hit block.
// No dependencies.
`timescale 1ns / 1ps
package rtnh_pkg;
    localparam int MESH_ID_BITS = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int QDEPTH = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;

    typedef struct packed {
        logic signed [31:0] a_x, a_y, a_z;
        logic signed [31:0] b_x, b_y, b_z;
        logic signed [31:0] c_x, c_y, c_z;
        logic [MESH_ID_BITS-1:0] mesh_id;
        logic last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic is_hit;
        logic [31:0] hit_distance;
        logic [MESH_ID_BITS-1:0] hit_mesh;
    } hit_out_t;

    typedef struct packed {
        logic signed [31:0] x, y, z;
    } vec_t;

    // front-end classification handed to the back end
    typedef struct packed {
        vec_t a, b, c, n;
        logic signed [31:0] q;
        logic signed [31:0] num;
        logic [MESH_ID_BITS-1:0] mesh;
        logic last;
    } front_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] vsub1(input logic signed [31:0] u,
                                                 input logic signed [31:0] v);
        logic signed [65:0] d;
        d = 66'(u) - 66'(v);
        return sat32(d);
    endfunction

    function automatic vec_t vsub(input vec_t u, input vec_t v);
        vec_t r;
        r.x = vsub1(u.x, v.x);
        r.y = vsub1(u.y, v.y);
        r.z = vsub1(u.z, v.z);
        return r;
    endfunction
endpackage

// File: hdl/rtnh_front.sv
// Front end: accepts triangles, forms normal, q and num over a short sequence.
// Depends on rtnh_pkg.
`timescale 1ns / 1ps
module rtnh_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rtnh_pkg::tri_in_t    s_tri,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rtnh_pkg::vec_t       origin,
    input  rtnh_pkg::vec_t       dir,
    output rtnh_pkg::front_item_t f_item,
    output logic                 f_valid,
    input  logic                 f_ready
);
    import rtnh_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001, F_CROSS = 5'b00010, F_QMUL = 5'b00100,
        F_NMUL = 5'b01000, F_OUT = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;
    front_item_t item_reg;
    vec_t e1_reg, e2_reg, ao_reg;
    logic [1:0] step_reg;
    logic signed [65:0] acc_reg;
    logic signed [63:0] p0, p1;
    logic signed [31:0] m0a, m0b, m1a, m1b;
    logic signed [65:0] diffc, fl0, fl1;
    logic signed [31:0] cres;

    assign s_ready = (state_reg == F_IDLE);
    assign f_valid = (state_reg == F_OUT);
    assign f_item  = item_reg;

    // one cross component or one dot term pair per step
    always_comb begin
        m0a = '0; m0b = '0; m1a = '0; m1b = '0;
        case (step_reg)
            2'd0: begin m0a = e1_reg.y; m0b = e2_reg.z; m1a = e1_reg.z; m1b = e2_reg.y; end
            2'd1: begin m0a = e1_reg.z; m0b = e2_reg.x; m1a = e1_reg.x; m1b = e2_reg.z; end
            default: begin m0a = e1_reg.x; m0b = e2_reg.y; m1a = e1_reg.y; m1b = e2_reg.x; end
        endcase
        if (state_reg == F_QMUL || state_reg == F_NMUL) begin
            case (step_reg)
                2'd0: m0a = item_reg.n.x;
                2'd1: m0a = item_reg.n.y;
                default: m0a = item_reg.n.z;
            endcase
            if (state_reg == F_QMUL) begin
                case (step_reg)
                    2'd0: m0b = dir.x;
                    2'd1: m0b = dir.y;
                    default: m0b = dir.z;
                endcase
            end else begin
                case (step_reg)
                    2'd0: m0b = ao_reg.x;
                    2'd1: m0b = ao_reg.y;
                    default: m0b = ao_reg.z;
                endcase
            end
        end
    end

    assign p0 = m0a * m0b;
    assign p1 = m1a * m1b;
    assign diffc = (66'(p0) - 66'(p1)) >>> 16;
    assign fl0 = 66'(p0) >>> 16;
    assign fl1 = acc_reg + fl0;
    assign cres = sat32(diffc);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (s_valid) state_next = F_CROSS;
            F_CROSS: if (step_reg == 2'd2) state_next = F_QMUL;
            F_QMUL:  if (step_reg == 2'd2) state_next = F_NMUL;
            F_NMUL:  if (step_reg == 2'd2) state_next = F_OUT;
            F_OUT:   if (f_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg || state_reg == F_IDLE) step_reg <= '0;
            else step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    item_reg.a <= '{s_tri.a_x, s_tri.a_y, s_tri.a_z};
                    item_reg.b <= '{s_tri.b_x, s_tri.b_y, s_tri.b_z};
                    item_reg.c <= '{s_tri.c_x, s_tri.c_y, s_tri.c_z};
                    item_reg.mesh <= s_tri.mesh_id;
                    item_reg.last <= s_tri.last_triangle;
                    e1_reg <= vsub('{s_tri.b_x, s_tri.b_y, s_tri.b_z},
                                   '{s_tri.a_x, s_tri.a_y, s_tri.a_z});
                    e2_reg <= vsub('{s_tri.c_x, s_tri.c_y, s_tri.c_z},
                                   '{s_tri.a_x, s_tri.a_y, s_tri.a_z});
                    ao_reg <= vsub('{s_tri.a_x, s_tri.a_y, s_tri.a_z}, origin);
                end
                acc_reg <= '0;
            end
            F_CROSS: begin
                case (step_reg)
                    2'd0: item_reg.n.x <= cres;
                    2'd1: item_reg.n.y <= cres;
                    default: item_reg.n.z <= cres;
                endcase
                acc_reg <= '0;
            end
            F_QMUL: begin
                if (step_reg == 2'd2) begin
                    item_reg.q <= sat32(fl1);
                    acc_reg <= '0;
                end else acc_reg <= fl1;
            end
            F_NMUL: begin
                if (step_reg == 2'd2) begin
                    item_reg.num <= sat32(fl1);
                    acc_reg <= '0;
                end else acc_reg <= fl1;
            end
            default: ;
        endcase
    end
endmodule

// File: hdl/rtnh_queue.sv
// Short FIFO between front end and back end.
// Depends on rtnh_pkg.
`timescale 1ns / 1ps
module rtnh_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtnh_pkg::front_item_t in_item,
    input  logic                  in_valid,
    output logic                  in_ready,
    output rtnh_pkg::front_item_t out_item,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import rtnh_pkg::*;

    front_item_t mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != QDEPTH[$clog2(QDEPTH):0]);
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{$clog2(QDEPTH){1'b0}}, push}
                               - {{$clog2(QDEPTH){1'b0}}, pop};
        end
    end
endmodule

// File: hdl/rtnh_div.sv
// Restoring divider: floor(num * 65536 / den) for 48-bit numerator, one bit per cycle.
// No dependencies beyond rtnh_pkg types.
`timescale 1ns / 1ps
module rtnh_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [47:0] quot
);
    import rtnh_pkg::*;

    logic [47:0] q_reg;
    logic [32:0] r_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] r_sh;
    logic [33:0] r_try;

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
    assign r_sh = {r_reg[31:0], q_reg[47]};
    assign r_try = {1'b0, r_sh} - {2'b00, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd48;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= {num, 16'd0};
            r_reg <= '0;
        end else if (busy) begin
            if (!r_try[33]) begin
                r_reg <= r_try[32:0];
                q_reg <= {q_reg[46:0], 1'b1};
            end else begin
                r_reg <= r_sh;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
    end
endmodule

// File: hdl/rtnh_back.sv
// Back end: divides for t, forms hit point, runs edge tests, keeps nearest hit.
// Depends on rtnh_pkg and rtnh_div.
`timescale 1ns / 1ps
module rtnh_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rtnh_pkg::front_item_t b_item,
    input  logic                  b_valid,
    output logic                  b_ready,
    input  rtnh_pkg::vec_t        origin,
    input  rtnh_pkg::vec_t        dir,
    output rtnh_pkg::hit_out_t    m_hit,
    output logic                  m_valid,
    input  logic                  m_ready
);
    import rtnh_pkg::*;

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001, B_DIV = 8'b00000010, B_HIT = 8'b00000100,
        B_EDGE = 8'b00001000, B_ECRS = 8'b00010000, B_EDOT = 8'b00100000,
        B_DONE = 8'b01000000, B_OUT = 8'b10000000
    } bstate_t;

    bstate_t state_reg, state_next;
    front_item_t it_reg;
    logic [31:0] t_reg;
    vec_t h_reg, u_reg, w_reg, k_reg;
    logic [1:0] edge_reg, step_reg;
    logic ok_reg, div_go;
    logic signed [65:0] acc_reg;
    logic best_valid_reg;
    logic [31:0] best_distance_reg;
    logic [MESH_ID_BITS-1:0] best_mesh_reg;
    hit_out_t out_reg;
    logic [31:0] anum, aq;
    logic div_busy;
    logic [47:0] quot;
    logic signed [31:0] m0a, m0b, m1a, m1b;
    logic signed [63:0] p0, p1;
    logic signed [65:0] hsum, cdiff, dsum;
    logic signed [32:0] t_s;
    vec_t ep, eq;
    logic qpos, npos, rej;

    assign anum = it_reg.num[31] ? 32'(-33'(it_reg.num)) : it_reg.num;
    assign aq   = it_reg.q[31] ? 32'(-33'(it_reg.q)) : it_reg.q;
    assign qpos = !it_reg.q[31];
    assign npos = !it_reg.num[31];
    assign rej  = (it_reg.q == '0) ||
                  ((it_reg.num != '0) && (npos != qpos));
    assign div_go = (state_reg == B_IDLE) && b_valid;

    rtnh_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(state_reg == B_DIV && step_reg == 2'd0),
        .num(anum), .den(aq), .busy(div_busy), .quot(quot)
    );

    assign b_ready = (state_reg == B_IDLE);
    assign m_valid = (state_reg == B_OUT);
    assign m_hit = out_reg;
    assign t_s = {1'b0, t_reg};

    // edge endpoints: (a,b), (b,c), (c,a)
    always_comb begin
        case (edge_reg)
            2'd0: begin ep = it_reg.a; eq = it_reg.b; end
            2'd1: begin ep = it_reg.b; eq = it_reg.c; end
            default: begin ep = it_reg.c; eq = it_reg.a; end
        endcase
    end

    always_comb begin
        m0a = '0; m0b = '0; m1a = '0; m1b = '0;
        case (state_reg)
            B_HIT: begin
                case (step_reg)
                    2'd0: m0a = dir.x;
                    2'd1: m0a = dir.y;
                    default: m0a = dir.z;
                endcase
            end
            B_ECRS: begin
                case (step_reg)
                    2'd0: begin m0a = u_reg.y; m0b = w_reg.z; m1a = u_reg.z; m1b = w_reg.y; end
                    2'd1: begin m0a = u_reg.z; m0b = w_reg.x; m1a = u_reg.x; m1b = w_reg.z; end
                    default: begin m0a = u_reg.x; m0b = w_reg.y; m1a = u_reg.y; m1b = w_reg.x; end
                endcase
            end
            B_EDOT: begin
                case (step_reg)
                    2'd0: begin m0a = it_reg.n.x; m0b = k_reg.x; end
                    2'd1: begin m0a = it_reg.n.y; m0b = k_reg.y; end
                    default: begin m0a = it_reg.n.z; m0b = k_reg.z; end
                endcase
            end
            default: ;
        endcase
    end

    // the hit-point product is 32x33 signed; t is held unsigned
    logic signed [64:0] ph;
    assign ph = m0a * t_s;
    assign p0 = m0a * m0b;
    assign p1 = m1a * m1b;
    always_comb begin
        case (step_reg)
            2'd0: hsum = 66'(origin.x) + (66'(ph) >>> 16);
            2'd1: hsum = 66'(origin.y) + (66'(ph) >>> 16);
            default: hsum = 66'(origin.z) + (66'(ph) >>> 16);
        endcase
    end
    assign cdiff = (66'(p0) - 66'(p1)) >>> 16;
    assign dsum  = acc_reg + (66'(p0) >>> 16);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (b_valid) state_next = B_DIV;
            B_DIV: begin
                if (rej) state_next = B_DONE;
                else if (step_reg != 2'd0 && !div_busy) state_next = B_HIT;
            end
            B_HIT:  if (step_reg == 2'd2) state_next = B_EDGE;
            B_EDGE: state_next = B_ECRS;
            B_ECRS: if (step_reg == 2'd2) state_next = B_EDOT;
            B_EDOT: begin
                if (step_reg == 2'd2) begin
                    if (edge_reg == 2'd2) state_next = B_DONE;
                    else state_next = B_EDGE;
                end
            end
            B_DONE: state_next = it_reg.last ? B_OUT : B_IDLE;
            B_OUT:  if (m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            step_reg <= '0;
            best_valid_reg <= 1'b0;
            best_distance_reg <= '0;
            best_mesh_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) step_reg <= '0;
            else if (state_reg == B_DIV) step_reg <= 2'd1;
            else if (state_reg == B_HIT || state_reg == B_ECRS || state_reg == B_EDOT)
                step_reg <= step_reg + 2'd1;
            if (state_reg == B_DONE) begin
                if (it_reg.last) begin
                    best_valid_reg <= 1'b0;
                    best_distance_reg <= '0;
                    best_mesh_reg <= '0;
                end else if (ok_reg && (!best_valid_reg || t_reg < best_distance_reg)) begin
                    best_valid_reg <= 1'b1;
                    best_distance_reg <= t_reg;
                    best_mesh_reg <= it_reg.mesh;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (div_go) it_reg <= b_item;
                edge_reg <= '0;
            end
            B_DIV: begin
                ok_reg <= !rej;
                t_reg <= (quot[47:32] != '0) ? 32'hffffffff : quot[31:0];
            end
            B_HIT: begin
                case (step_reg)
                    2'd0: h_reg.x <= sat32(hsum);
                    2'd1: h_reg.y <= sat32(hsum);
                    default: h_reg.z <= sat32(hsum);
                endcase
            end
            B_EDGE: begin
                u_reg <= vsub(eq, ep);
                w_reg <= vsub(h_reg, ep);
                acc_reg <= '0;
            end
            B_ECRS: begin
                case (step_reg)
                    2'd0: k_reg.x <= sat32(cdiff);
                    2'd1: k_reg.y <= sat32(cdiff);
                    default: k_reg.z <= sat32(cdiff);
                endcase
            end
            B_EDOT: begin
                acc_reg <= dsum;
                if (step_reg == 2'd2) begin
                    if (sat32(dsum) < 0) ok_reg <= 1'b0;
                    edge_reg <= edge_reg + 2'd1;
                end
            end
            B_DONE: begin
                if (ok_reg && (!best_valid_reg || t_reg < best_distance_reg)) begin
                    out_reg.is_hit <= 1'b1;
                    out_reg.hit_distance <= t_reg;
                    out_reg.hit_mesh <= it_reg.mesh;
                end else begin
                    out_reg.is_hit <= best_valid_reg;
                    out_reg.hit_distance <= best_distance_reg;
                    out_reg.hit_mesh <= best_mesh_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

// File: hdl/ray_triangle_nearest_hit.sv
// Nearest ray/triangle hit over a stream of triangles: top level.
// Depends on rtnh_pkg, rtnh_front, rtnh_queue, rtnh_back and the macros header.
`timescale 1ns / 1ps
`include "ray_triangle_nearest_hit_macros.svh"
// The ray sits in six configuration registers; triangles stream in and one
// result leaves on each triangle marked last. The front end takes one
// triangle at a time (three cross components, then q and num as three-term
// dot products on one shared multiplier). The back end loads a triangle,
// then sends a rejected one from the divide state straight on to update the
// kept hit; a candidate runs the bit-serial divide in the divide state, then
// the hit point and the edge tests for (a,b), (b,c) and (c,a) before that update. A triangle
// marked last adds the result transaction. The divider sets the rate for
// candidates. A two-entry queue lets the front end run ahead of the back end.
module ray_triangle_nearest_hit (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtnh_pkg::tri_in_t   s_data,
    input  logic                s_valid,
    output logic                s_ready,
    output rtnh_pkg::hit_out_t  m_data,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic [rtnh_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);
    import rtnh_pkg::*;

    vec_t origin_reg, dir_reg;
    front_item_t f_item, q_item;
    logic f_valid, f_ready, q_valid, q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            dir_reg <= '{32'sd0, 32'sd0, 32'sd65536};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X: origin_reg.x <= cfg_data;
                REG_ORIGIN_Y: origin_reg.y <= cfg_data;
                REG_ORIGIN_Z: origin_reg.z <= cfg_data;
                REG_DIR_X:    dir_reg.x <= cfg_data;
                REG_DIR_Y:    dir_reg.y <= cfg_data;
                REG_DIR_Z:    dir_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    rtnh_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tri(s_data), .s_valid(s_valid),
        .s_ready(s_ready), .origin(origin_reg), .dir(dir_reg),
        .f_item(f_item), .f_valid(f_valid), .f_ready(f_ready)
    );

    rtnh_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_item(f_item), .in_valid(f_valid),
        .in_ready(f_ready), .out_item(q_item), .out_valid(q_valid),
        .out_ready(q_ready)
    );

    rtnh_back u_back (
        .aclk(aclk), .aresetn(aresetn), .b_item(q_item), .b_valid(q_valid),
        .b_ready(q_ready), .origin(origin_reg), .dir(dir_reg),
        .m_hit(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );

    `RTNH_ASSERT_IMPL(a_miss_zero, aclk, aresetn, (m_valid && !m_data.is_hit) |-> (m_data.hit_distance == '0 && m_data.hit_mesh == '0))
    `RTNH_ASSERT_IMPL(a_front_hold, aclk, aresetn, (f_valid && !f_ready) |=> f_valid)
    `RTNH_ASSERT_NORST(a_reset_idle, aclk, !aresetn |=> !m_valid)
endmodule
